// File: hdl/assert_macros.svh
// Assertion macros shared by the eased value tween RTL.
// Included by the top level; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define EVT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define EVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define EVT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define EVT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/evt_pkg.sv
// Shared types, constants and curve-table builders for the eased value tween.
// No dependencies.
package evt_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int CURVE_ENTRIES_DEF = 256;
   localparam int ACC_W             = 24;
   localparam int DELTA_W           = 20;
   localparam int LEVEL_W           = 32;
   localparam int EXP_W             = 16;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int QUEUE_DEPTH       = 2;
   localparam int LOG_W             = 17;  // Q1.16, up to 1.0
   localparam int EXPV_W            = 18;  // Q2.16, up to 2.0
   localparam logic [ACC_W-1:0] ACC_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_TIME    = 3'd0,
      CSR_RAMP_DURATION = 3'd1,
      CSR_EASE_EXPONENT = 3'd2,
      CSR_EASE_OUT_MODE = 3'd3,
      CSR_START_LEVEL   = 3'd4,
      CSR_TARGET_LEVEL  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_RESTART = 2'd0,
      KIND_WAIT    = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_RAMP    = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type     kind;
      logic [ACC_W-1:0] run;
   } job_type;

   typedef struct packed {
      logic [ACC_W-1:0]          delay_time;
      logic [ACC_W-1:0]          ramp_duration;
      logic [EXP_W-1:0]          ease_exponent;
      logic                      ease_out_mode;
      logic signed [LEVEL_W-1:0] start_level;
      logic signed [LEVEL_W-1:0] target_level;
   } cfg_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   // log2 of y (Q2.30 in [1,2]) as Q1.16, by repeated squaring
   function automatic logic [LOG_W-1:0] log_q30(input logic [63:0] y_in);
      logic [63:0]      y;
      logic [LOG_W-1:0] r;
      y = y_in;
      r = '0;
      if (y >= (64'd2 << 30)) begin
         r = LOG_W'(65536);
      end else begin
         for (int k = 15; k >= 0; k--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
               y    = y >> 1;
               r[k] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // smallest Q2.16 y in [1,2] whose log2 reaches v
   function automatic logic [EXPV_W-1:0] exp_search(input logic [63:0] v);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo  = 64'd65536;
      hi  = 64'd131072;
      mid = '0;
      for (int j = 0; j < 20; j++) begin
         if (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (64'(log_q30(mid << 14)) >= v) begin
               hi = mid;
            end else begin
               lo = mid + 64'd1;
            end
         end
      end
      return EXPV_W'(lo);
   endfunction

endpackage

// File: hdl/evt_front.sv
// Front end: accepts tick beats, updates the elapsed-time accumulators
// and classifies each beat into a job. Uses evt_pkg.
module evt_front (
   input  logic                           clock,
   input  logic                           reset,
   input  evt_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [evt_pkg::DELTA_W-1:0]    req_time_delta,
   input  evt_pkg::queue_status_type      q_status,
   output logic                           push,
   output evt_pkg::job_type               push_job
);

   logic [evt_pkg::ACC_W-1:0] delay_ff, delay_in;
   logic [evt_pkg::ACC_W-1:0] run_ff, run_in;
   logic [evt_pkg::ACC_W:0]   delay_sum;
   logic [evt_pkg::ACC_W:0]   run_sum;
   logic [evt_pkg::ACC_W-1:0] delay_sat;
   logic [evt_pkg::ACC_W-1:0] run_sat;
   logic                      accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept;

   assign delay_sum = {1'b0, delay_ff} + (evt_pkg::ACC_W+1)'(req_time_delta);
   assign run_sum   = {1'b0, run_ff} + (evt_pkg::ACC_W+1)'(req_time_delta);
   assign delay_sat = delay_sum[evt_pkg::ACC_W] ? evt_pkg::ACC_MAX
                                                : delay_sum[evt_pkg::ACC_W-1:0];
   assign run_sat   = run_sum[evt_pkg::ACC_W] ? evt_pkg::ACC_MAX
                                              : run_sum[evt_pkg::ACC_W-1:0];

   always_comb begin
      delay_in      = delay_ff;
      run_in        = run_ff;
      push_job.kind = evt_pkg::KIND_RESTART;
      push_job.run  = run_sat;
      if (accept) begin
         if (req_command) begin
            delay_in      = '0;
            run_in        = '0;
            push_job.kind = evt_pkg::KIND_RESTART;
         end else begin
            delay_in = delay_sat;
            if (delay_sat < cfg.delay_time) begin
               push_job.kind = evt_pkg::KIND_WAIT;
            end else begin
               run_in = run_sat;
               if (run_sat >= cfg.ramp_duration) begin
                  push_job.kind = evt_pkg::KIND_DONE;
               end else begin
                  push_job.kind = evt_pkg::KIND_RAMP;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         run_ff   <= '0;
      end else begin
         delay_ff <= delay_in;
         run_ff   <= run_in;
      end
   end

endmodule

// File: hdl/evt_queue.sv
// Short job queue between the front end and the back end.
// Uses evt_pkg.
module evt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  evt_pkg::job_type          push_job,
   input  logic                      pop,
   output evt_pkg::job_type          pop_job,
   output evt_pkg::queue_status_type status
);

   localparam int PTR_W = (evt_pkg::QUEUE_DEPTH > 1) ? $clog2(evt_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(evt_pkg::QUEUE_DEPTH + 1);

   evt_pkg::job_type   slot_ff [evt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(evt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pop_job          = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CNT_W'(evt_pkg::QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/evt_back.sv
// Back end: bit-serial divide, log2/exp2 power through curve tables,
// blend and result register. Uses evt_pkg.
module evt_back #(
   parameter int FRACTION_BITS       = evt_pkg::FRACTION_BITS_DEF,
   parameter int CURVE_TABLE_ENTRIES = evt_pkg::CURVE_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  evt_pkg::cfg_type                   cfg,
   input  evt_pkg::queue_status_type          q_status,
   input  evt_pkg::job_type                   q_job,
   output logic                               q_pop,
   output evt_pkg::back_status_type           status,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [evt_pkg::LEVEL_W-1:0] rsp_level,
   output logic                               rsp_done_res,
   output logic                               rsp_waiting
);

   localparam int F      = FRACTION_BITS;
   localparam int IDX_W  = $clog2(CURVE_TABLE_ENTRIES + 1);
   localparam int CNT_W  = $clog2(F);
   localparam int REM_W  = evt_pkg::ACC_W + 1;
   localparam int FRAC_W = 31;
   localparam int S1_W   = FRAC_W + IDX_W;
   localparam int LGD_W  = evt_pkg::LOG_W + FRAC_W;
   localparam int MAG_W  = 21;
   localparam int EM_W   = evt_pkg::EXP_W + MAG_W;
   localparam int M_W    = EM_W - 12;
   localparam int H_W    = 17;
   localparam int S2_W   = H_W + IDX_W;
   localparam int EVD_W  = evt_pkg::EXPV_W + 16;
   localparam int SH_W   = 10;
   localparam int WIDE_W = evt_pkg::EXPV_W + F;
   localparam int DIFF_W = evt_pkg::LEVEL_W + 1;
   localparam int PROD_W = DIFF_W + F + 1;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_DIV   = 11'b000_0000_0010,
      ST_PICK  = 11'b000_0000_0100,
      ST_NORM  = 11'b000_0000_1000,
      ST_LOGA  = 11'b000_0001_0000,
      ST_LOGB  = 11'b000_0010_0000,
      ST_EXPA  = 11'b000_0100_0000,
      ST_EXPB  = 11'b000_1000_0000,
      ST_EXPC  = 11'b001_0000_0000,
      ST_BLEND = 11'b010_0000_0000,
      ST_SUM   = 11'b100_0000_0000
   } state_type;

   // curve tables, built at elaboration
   logic [evt_pkg::LOG_W-1:0]  lg_rom [CURVE_TABLE_ENTRIES + 1];
   logic [evt_pkg::EXPV_W-1:0] ex_rom [CURVE_TABLE_ENTRIES + 1];

   for (genvar gi = 0; gi <= CURVE_TABLE_ENTRIES; gi++) begin : g_rom
      localparam logic [63:0] LogArg = 64'h4000_0000 +
                                       ((64'(gi) << 30) / CURVE_TABLE_ENTRIES);
      localparam logic [63:0] ExpArg = (64'(gi) << 16) / CURVE_TABLE_ENTRIES;
      assign lg_rom[gi] = evt_pkg::log_q30(LogArg);
      assign ex_rom[gi] = evt_pkg::exp_search(ExpArg);
   end

   state_type                           state_ff, state_in;
   logic [REM_W-1:0]                    rem_ff, rem_in;
   logic [F-1:0]                        quo_ff, quo_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic [F-1:0]                        x_ff, x_in;
   logic [CNT_W-1:0]                    k_ff, k_in;
   logic [S1_W-1:0]                     s1_ff, s1_in;
   logic [evt_pkg::LOG_W-1:0]           lgb_ff, lgb_in;
   logic [LGD_W-1:0]                    lgd_ff, lgd_in;
   logic [EM_W-1:0]                     em_ff, em_in;
   logic [S2_W-1:0]                     s2_ff, s2_in;
   logic [evt_pkg::EXPV_W-1:0]          evb_ff, evb_in;
   logic [EVD_W-1:0]                    evd_ff, evd_in;
   logic [F:0]                          eased_ff, eased_in;
   logic signed [PROD_W-1:0]            prod_ff, prod_in;
   logic signed [evt_pkg::LEVEL_W-1:0]  held_ff, held_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [evt_pkg::LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic                                rsp_done_ff, rsp_done_in;
   logic                                rsp_wait_ff, rsp_wait_in;

   logic                                out_free;
   logic [REM_W-1:0]                    rem_sh;
   logic                                rem_ge;
   logic [FRAC_W-1:0]                   frac;
   logic [IDX_W-1:0]                    idx1;
   logic [evt_pkg::LOG_W-1:0]           lg_lo, lg_hi, lg_sum;
   logic [MAG_W-1:0]                    mag;
   logic [M_W-1:0]                      m_val;
   logic [H_W-1:0]                      h_val;
   logic [IDX_W:0]                      idx2;
   logic                                idx2_top;
   logic [IDX_W-1:0]                    idx2c;
   logic [evt_pkg::EXPV_W-1:0]          ex_lo, ex_hi, ev_sum;
   logic [SH_W-1:0]                     sh_amt;
   logic [WIDE_W-1:0]                   wide, pw_raw;
   logic [F:0]                          pw;
   logic signed [DIFF_W-1:0]            diff;
   logic signed [PROD_W-1:0]            prod_sh;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rem_sh = {rem_ff[REM_W-2:0], 1'b0};
   assign rem_ge = (rem_sh >= REM_W'(cfg.ramp_duration));

   assign frac   = {x_ff[F-2:0], {(32 - F){1'b0}}};
   assign idx1   = s1_ff[S1_W-1:FRAC_W];
   assign lg_lo  = lg_rom[idx1];
   assign lg_hi  = lg_rom[idx1 + 1'b1];
   assign lg_sum = lgb_ff + lgd_ff[LGD_W-1:FRAC_W];
   assign mag    = ((MAG_W'(k_ff) + MAG_W'(1)) << 16) - MAG_W'(lg_sum);

   assign m_val    = em_ff[EM_W-1:12];
   assign h_val    = H_W'(65536) - {1'b0, m_val[15:0]};
   assign idx2     = s2_ff[S2_W-1:16];
   assign idx2_top = (idx2 >= (IDX_W+1)'(CURVE_TABLE_ENTRIES));
   assign idx2c    = idx2_top ? IDX_W'(CURVE_TABLE_ENTRIES - 1) : idx2[IDX_W-1:0];
   assign ex_lo    = ex_rom[idx2c];
   assign ex_hi    = ex_rom[idx2c + 1'b1];

   assign ev_sum = evb_ff + evd_ff[EVD_W-1:16];
   assign sh_amt = SH_W'(m_val[M_W-1:16]) + SH_W'(17);
   assign wide   = {ev_sum, {F{1'b0}}};
   assign pw_raw = (sh_amt >= SH_W'(64)) ? '0 : (wide >> sh_amt);
   assign pw     = (pw_raw > WIDE_W'(ONE)) ? ONE : pw_raw[F:0];

   assign diff    = DIFF_W'(cfg.target_level) - DIFF_W'(cfg.start_level);
   assign prod_sh = prod_ff >>> F;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      s1_in        = s1_ff;
      lgb_in       = lgb_ff;
      lgd_in       = lgd_ff;
      em_in        = em_ff;
      s2_in        = s2_ff;
      evb_in       = evb_ff;
      evd_in       = evd_ff;
      eased_in     = eased_ff;
      prod_in      = prod_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_level_in = rsp_level_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_wait_in  = rsp_wait_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty && out_free) begin
               q_pop = 1'b1;
               unique case (q_job.kind)
                  evt_pkg::KIND_RAMP: begin
                     rem_in   = REM_W'(q_job.run);
                     quo_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_DIV;
                  end
                  evt_pkg::KIND_DONE: begin
                     held_in      = cfg.target_level;
                     rsp_valid_in = 1'b1;
                     rsp_level_in = cfg.target_level;
                     rsp_done_in  = 1'b1;
                     rsp_wait_in  = 1'b0;
                  end
                  evt_pkg::KIND_WAIT: begin
                     rsp_valid_in = 1'b1;
                     rsp_level_in = held_ff;
                     rsp_done_in  = 1'b0;
                     rsp_wait_in  = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_level_in = held_ff;
                     rsp_done_in  = 1'b0;
                     rsp_wait_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? (rem_sh - REM_W'(cfg.ramp_duration)) : rem_sh;
            quo_in = {quo_ff[F-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(F - 1)) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            k_in = '0;
            if (cfg.ease_exponent == '0) begin
               eased_in = {1'b0, quo_ff};
               state_in = ST_BLEND;
            end else if (quo_ff == '0) begin
               eased_in = '0;
               state_in = ST_BLEND;
            end else begin
               x_in     = cfg.ease_out_mode ? F'(ONE - {1'b0, quo_ff}) : quo_ff;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (x_ff[F-1]) begin
               s1_in    = S1_W'(frac) * S1_W'(CURVE_TABLE_ENTRIES);
               state_in = ST_LOGA;
            end else begin
               x_in = {x_ff[F-2:0], 1'b0};
               k_in = k_ff + 1'b1;
            end
         end
         ST_LOGA: begin
            lgb_in   = lg_lo;
            lgd_in   = LGD_W'(lg_hi - lg_lo) * LGD_W'(s1_ff[FRAC_W-1:0]);
            state_in = ST_LOGB;
         end
         ST_LOGB: begin
            em_in    = EM_W'(cfg.ease_exponent) * EM_W'(mag);
            state_in = ST_EXPA;
         end
         ST_EXPA: begin
            s2_in    = S2_W'(h_val) * S2_W'(CURVE_TABLE_ENTRIES);
            state_in = ST_EXPB;
         end
         ST_EXPB: begin
            if (idx2_top) begin
               evb_in = ex_rom[CURVE_TABLE_ENTRIES];
               evd_in = '0;
            end else begin
               evb_in = ex_lo;
               evd_in = EVD_W'(ex_hi - ex_lo) * EVD_W'(s2_ff[15:0]);
            end
            state_in = ST_EXPC;
         end
         ST_EXPC: begin
            eased_in = cfg.ease_out_mode ? (ONE - pw) : pw;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            prod_in  = PROD_W'(diff) * $signed({{(PROD_W - F - 1){1'b0}}, eased_ff});
            state_in = ST_SUM;
         end
         ST_SUM: begin
            held_in      = cfg.start_level + prod_sh[evt_pkg::LEVEL_W-1:0];
            rsp_valid_in = 1'b1;
            rsp_level_in = cfg.start_level + prod_sh[evt_pkg::LEVEL_W-1:0];
            rsp_done_in  = 1'b0;
            rsp_wait_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      x_ff         <= x_in;
      k_ff         <= k_in;
      s1_ff        <= s1_in;
      lgb_ff       <= lgb_in;
      lgd_ff       <= lgd_in;
      em_ff        <= em_in;
      s2_ff        <= s2_in;
      evb_ff       <= evb_in;
      evd_ff       <= evd_in;
      eased_ff     <= eased_in;
      prod_ff      <= prod_in;
      rsp_level_ff <= rsp_level_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_wait_ff  <= rsp_wait_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.busy  = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_waiting  = rsp_wait_ff;

endmodule

// File: hdl/eased_value_tween.sv
// Top level of the eased value tween: configuration registers, front end,
// job queue and back end. Uses evt_pkg, evt_front, evt_queue, evt_back.
//
//   channel  direction  handshake         beat
//   req_     in         valid / stall     command, time_delta
//   rsp_     out        valid / stall     level, done_res, waiting
//   csr_     in         write_enable      index, write_data
//
// Restart, wait and done beats are answered straight from the idle state when
// they leave the queue. A ramp beat passes through the bit-serial divider, and
// with a power curve through the normalizing shifter and the log2/exp2 table
// steps, before the blend and sum. The front end keeps taking beats until the
// two-entry queue is full. Reset is synchronous and clears all control state.
`include "assert_macros.svh"

module eased_value_tween #(
   parameter int FRACTION_BITS       = evt_pkg::FRACTION_BITS_DEF,
   parameter int CURVE_TABLE_ENTRIES = evt_pkg::CURVE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [evt_pkg::DELTA_W-1:0]         req_time_delta,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [evt_pkg::LEVEL_W-1:0]  rsp_level,
   output logic                                rsp_done_res,
   output logic                                rsp_waiting,
   input  logic                                csr_write_enable,
   input  logic [evt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [evt_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   evt_pkg::cfg_type          cfg_ff, cfg_in;
   evt_pkg::queue_status_type q_status;
   evt_pkg::back_status_type  back_status;
   evt_pkg::job_type          push_job;
   evt_pkg::job_type          pop_job;
   logic                      push;
   logic                      pop;
   logic                      done_beat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (evt_pkg::csr_index_type'(csr_index))
            evt_pkg::CSR_DELAY_TIME:    cfg_in.delay_time    = csr_write_data[23:0];
            evt_pkg::CSR_RAMP_DURATION: cfg_in.ramp_duration = csr_write_data[23:0];
            evt_pkg::CSR_EASE_EXPONENT: cfg_in.ease_exponent = csr_write_data[15:0];
            evt_pkg::CSR_EASE_OUT_MODE: cfg_in.ease_out_mode = csr_write_data[0];
            evt_pkg::CSR_START_LEVEL:   cfg_in.start_level   = csr_write_data;
            evt_pkg::CSR_TARGET_LEVEL:  cfg_in.target_level  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   evt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_time_delta (req_time_delta),
      .q_status       (q_status),
      .push           (push),
      .push_job       (push_job)
   );

   evt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   evt_back #(
      .FRACTION_BITS       (FRACTION_BITS),
      .CURVE_TABLE_ENTRIES (CURVE_TABLE_ENTRIES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_status     (q_status),
      .q_job        (pop_job),
      .q_pop        (pop),
      .status       (back_status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_level    (rsp_level),
      .rsp_done_res (rsp_done_res),
      .rsp_waiting  (rsp_waiting)
   );

   assign done_beat = rsp_valid && rsp_done_res;

   `EVT_ASSERT_IMPLIES(a_done_wait_excl, clock, reset, rsp_valid, !(rsp_done_res && rsp_waiting))
   `EVT_ASSERT_IMPLIES(a_done_level, clock, reset, done_beat, rsp_level == cfg_ff.target_level)
   `EVT_ASSERT_IMPLIES(a_busy_no_beat, clock, reset, back_status.busy, !rsp_valid)
   `EVT_ASSERT_NEXT(a_q_idle, clock, reset, !q_status.not_empty && !push, !q_status.not_empty)

endmodule

// File: tb/eased_value_tween_tb.sv
// Self-checking testbench for eased_value_tween: directed table, then random ticks.
// Predicts each result beat with its own curve tables; depends on evt_pkg and the RTL.
module eased_value_tween_tb;

   localparam int FB = 16;
   localparam int NTAB = 256;
   localparam longint ONE = 64'd1 << FB;
   localparam int LIMIT = 900000;
   localparam int TAIL = 60;
   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef struct {
      logic signed [31:0] level;
      logic done;
      logic waiting;
   } tween_out_type;

   typedef struct {
      bit typed;
      tween_out_type want;
   } pin_type;

   typedef enum {ROW_CSR, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [31:0] a;
      logic [31:0] b;
      int reps;
      bit typed;
      logic [31:0] lvl;
      bit dn;
      bit wt;
   } row_type;

   logic clock, reset;
   logic req_valid, req_stall, req_command;
   logic [evt_pkg::DELTA_W-1:0] req_time_delta;
   logic rsp_valid, rsp_stall;
   logic signed [evt_pkg::LEVEL_W-1:0] rsp_level;
   logic rsp_done_res, rsp_waiting;
   logic csr_write_enable;
   logic [evt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [evt_pkg::CSR_DATA_W-1:0] csr_write_data;

   eased_value_tween dut (.*);

   logic [63:0] log_tab [0:NTAB];
   logic [63:0] exp_tab [0:NTAB];
   evt_pkg::cfg_type cfg_now;
   logic [23:0] delay_acc, run_acc;
   logic signed [31:0] held;
   tween_out_type level_q [$];
   pin_type pins [$];
   int errors, cycles, burst_left, pat_left, pat_mode;

   // log2 of y (Q2.30, 1..2) as Q1.16 by squaring
   function automatic logic [63:0] frac_log2(input logic [63:0] y_in);
      logic [63:0] y, r;
      y = y_in;
      r = 0;
      if (y >= (64'd2 << 30)) return ONE;
      for (int k = 15; k >= 0; k--) begin
         y = (y * y) >> 30;
         if (y >= (64'd2 << 30)) begin
            y = y >> 1;
            r = r | (64'd1 << k);
         end
      end
      return r;
   endfunction

   task automatic fill_curves();
      logic [63:0] goal, lo, hi, mid;
      for (int i = 0; i <= NTAB; i++) begin
         goal = (64'(i) << 16) / NTAB;
         log_tab[i] = frac_log2((64'd1 << 30) + ((64'(i) << 30) / NTAB));
         lo = ONE;
         hi = 2 * ONE;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (frac_log2(mid << 14) >= goal) hi = mid;
            else lo = mid + 1;
         end
         exp_tab[i] = lo;
      end
   endtask

   function automatic logic [63:0] curve_pow(input logic [63:0] x, input logic [15:0] e);
      logic [63:0] w, s, idx, rem, lg, mag, m, h, ev, r;
      int p;
      p = 0;
      if (x >= ONE) return ONE;
      for (int b = 0; b < FB; b++) if (x[b]) p = b;
      w = (x << (31 - p)) & 64'hFFFF_FFFF;
      s = (w & 64'h7FFF_FFFF) * NTAB;
      idx = s >> 31;
      rem = s & 64'h7FFF_FFFF;
      lg = log_tab[idx] + (((log_tab[idx+1] - log_tab[idx]) * rem) >> 31);
      mag = 64'(FB - p) * ONE - lg;
      m = (64'(e) * mag) >> 12;
      h = ONE - (m & 64'hFFFF);
      s = h * NTAB;
      idx = s >> 16;
      rem = s & 64'hFFFF;
      if (idx >= NTAB) ev = exp_tab[NTAB];
      else ev = exp_tab[idx] + (((exp_tab[idx+1] - exp_tab[idx]) * rem) >> 16);
      m = (m >> 16) + 17;
      r = (m >= 64) ? 64'd0 : ((ev << FB) >> m);
      return (r > ONE) ? ONE : r;
   endfunction

   function automatic logic [23:0] acc_add(input logic [23:0] a, input logic [19:0] d);
      logic [24:0] s;
      s = 25'(a) + 25'(d);
      return (s > 25'hFF_FFFF) ? 24'hFF_FFFF : s[23:0];
   endfunction

   function automatic tween_out_type tween_step(input logic cmd, input logic [19:0] delta);
      tween_out_type o;
      logic [63:0] t, eased;
      longint diff, prod;
      o.done = 0;
      o.waiting = 0;
      if (cmd == CMD_RESTART) begin
         delay_acc = 0;
         run_acc = 0;
      end else begin
         delay_acc = acc_add(delay_acc, delta);
         if (delay_acc < cfg_now.delay_time) begin
            o.waiting = 1;
         end else begin
            run_acc = acc_add(run_acc, delta);
            if (run_acc >= cfg_now.ramp_duration) begin
               held = cfg_now.target_level;
               o.done = 1;
            end else begin
               t = (64'(run_acc) << FB) / 64'(cfg_now.ramp_duration);
               eased = t;
               if (cfg_now.ease_exponent != 0) begin
                  if (cfg_now.ease_out_mode)
                     eased = ONE - curve_pow(ONE - t, cfg_now.ease_exponent);
                  else
                     eased = (t == 0) ? 64'd0 : curve_pow(t, cfg_now.ease_exponent);
               end
               diff = longint'($signed(cfg_now.target_level)) -
                      longint'($signed(cfg_now.start_level));
               prod = (diff * longint'(eased)) >>> FB;
               held = 32'(longint'($signed(cfg_now.start_level)) + prod);
            end
         end
      end
      o.level = held;
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // predictor follows register writes and accepted request beats
   always @(posedge clock) begin
      tween_out_type r;
      pin_type p;
      if (reset) begin
         cfg_now <= '0;
         delay_acc = 0;
         run_acc = 0;
         held = 0;
      end else begin
         if (csr_write_enable) begin
            case (evt_pkg::csr_index_type'(csr_index))
               evt_pkg::CSR_DELAY_TIME:    cfg_now.delay_time <= csr_write_data[23:0];
               evt_pkg::CSR_RAMP_DURATION: cfg_now.ramp_duration <= csr_write_data[23:0];
               evt_pkg::CSR_EASE_EXPONENT: cfg_now.ease_exponent <= csr_write_data[15:0];
               evt_pkg::CSR_EASE_OUT_MODE: cfg_now.ease_out_mode <= csr_write_data[0];
               evt_pkg::CSR_START_LEVEL:   cfg_now.start_level <= csr_write_data;
               evt_pkg::CSR_TARGET_LEVEL:  cfg_now.target_level <= csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            r = tween_step(req_command, req_time_delta);
            p = pins.pop_front();
            level_q.insert(level_q.size(), p.typed ? p.want : r);
         end
      end
   end

   always @(posedge clock) begin
      tween_out_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (level_q.size() == 0) begin
            $display("%0t: unexpected result beat level=%h", $time, rsp_level);
            errors++;
         end else begin
            w = level_q.pop_front();
            if (rsp_level !== w.level) begin
               $display("%0t: level expected %h actual %h", $time, w.level, rsp_level);
               errors++;
            end
            if (rsp_done_res !== w.done) begin
               $display("%0t: done_res expected %b actual %b", $time, w.done, rsp_done_res);
               errors++;
            end
            if (rsp_waiting !== w.waiting) begin
               $display("%0t: waiting expected %b actual %b", $time, w.waiting, rsp_waiting);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         pat_left <= 0;
         pat_mode <= 0;
      end else begin
         if (pat_left == 0) begin
            pat_mode <= $urandom_range(0, 2);
            pat_left <= $urandom_range(20, 200);
         end else begin
            pat_left <= pat_left - 1;
         end
         case (pat_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("eased_value_tween_tb NOT OK");
         $finish;
      end
   end

   task automatic send_beat(input logic cmd, input logic [19:0] delta, input pin_type pin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      pins.insert(pins.size(), pin);
      req_valid <= 1;
      req_command <= cmd;
      req_time_delta <= delta;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (level_q.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
   endtask

   task automatic csr_put(input evt_pkg::csr_index_type idx, input logic [31:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] pick_time();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 1;
         2: return 24'hFF_FFFF;
         3: return 24'($urandom_range(0, 24'hFF_FFFF));
         default: return 24'($urandom_range(2, 5000));
      endcase
   endfunction

   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   row_type plan [32];

   initial begin
      pin_type pin;
      logic [23:0] dl, du;
      longint span;
      int step;
      int sel;
      logic [19:0] d;
      reset <= 1;
      req_valid <= 0;
      req_command <= 0;
      req_time_delta <= 0;
      csr_write_enable <= 0;
      csr_index <= 0;
      csr_write_data <= 0;
      errors = 0;
      cycles = 0;
      burst_left = 0;
      fill_curves();
      plan = '{
         '{ROW_BEAT, CMD_ADVANCE, 0, 1, 1, 0, 1, 0},
         '{ROW_BEAT, CMD_RESTART, 20'hFFFFF, 1, 1, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 20'hFFFFF, 1, 1, 0, 1, 0},
         '{ROW_CSR, evt_pkg::CSR_DELAY_TIME, 100, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_RAMP_DURATION, 1000, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_EASE_EXPONENT, 32'h2000, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_EASE_OUT_MODE, 0, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_START_LEVEL, 32'h8000_0000, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_TARGET_LEVEL, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_RESTART, 0, 1, 1, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 60, 1, 1, 0, 0, 1},
         '{ROW_BEAT, CMD_ADVANCE, 40, 1, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 0, 1, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 500, 1, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 460, 1, 1, 32'h7FFF_FFFF, 1, 0},
         '{ROW_BEAT, CMD_ADVANCE, 1, 1, 1, 32'h7FFF_FFFF, 1, 0},
         '{ROW_BEAT, CMD_RESTART, 0, 1, 1, 32'h7FFF_FFFF, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 100, 1, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_DELAY_TIME, 0, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_RAMP_DURATION, 32'hFF_FFFF, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_EASE_EXPONENT, 32'hFFFF, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_START_LEVEL, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_TARGET_LEVEL, 32'h8000_0000, 0, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_RESTART, 0, 1, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 0, 1, 1, 32'h7FFF_FFFF, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_EASE_OUT_MODE, 1, 0, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 0, 1, 1, 32'h7FFF_FFFF, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 20'hFFFFF, 17, 0, 0, 0, 0},
         '{ROW_CSR, evt_pkg::CSR_EASE_EXPONENT, 0, 0, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_RESTART, 0, 1, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 80000, 3, 0, 0, 0, 0},
         '{ROW_BEAT, CMD_ADVANCE, 12345, 1, 0, 0, 0, 0}
      };
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            csr_put(evt_pkg::csr_index_type'(plan[i].a[2:0]), plan[i].b);
         end else begin
            for (int k = 0; k < plan[i].reps; k++) begin
               pin.typed = plan[i].typed;
               pin.want.level = plan[i].lvl;
               pin.want.done = plan[i].dn;
               pin.want.waiting = plan[i].wt;
               send_beat(plan[i].a[0], plan[i].b[19:0], pin);
            end
         end
      end

      pin.typed = 0;
      for (int ph = 0; ph < 8; ph++) begin
         settle();
         if (ph == 0) begin
            csr_put(evt_pkg::CSR_DELAY_TIME, 32'hFF_FFFF);
            csr_put(evt_pkg::CSR_RAMP_DURATION, 32'hFF_FFFF);
            csr_put(evt_pkg::CSR_EASE_EXPONENT, 32'hFFFF);
            csr_put(evt_pkg::CSR_EASE_OUT_MODE, 1);
            csr_put(evt_pkg::CSR_START_LEVEL, 32'h7FFF_FFFF);
            csr_put(evt_pkg::CSR_TARGET_LEVEL, 32'h8000_0000);
         end else if (ph == 1) begin
            csr_put(evt_pkg::CSR_DELAY_TIME, 0);
            csr_put(evt_pkg::CSR_RAMP_DURATION, 0);
            csr_put(evt_pkg::CSR_EASE_EXPONENT, 0);
            csr_put(evt_pkg::CSR_EASE_OUT_MODE, 0);
            csr_put(evt_pkg::CSR_START_LEVEL, 32'h8000_0000);
            csr_put(evt_pkg::CSR_TARGET_LEVEL, 32'h7FFF_FFFF);
         end else begin
            csr_put(evt_pkg::CSR_DELAY_TIME, pick_time());
            csr_put(evt_pkg::CSR_RAMP_DURATION, pick_time());
            case ($urandom_range(0, 3))
               0: csr_put(evt_pkg::CSR_EASE_EXPONENT, 0);
               1: csr_put(evt_pkg::CSR_EASE_EXPONENT, 32'h1000);
               default: csr_put(evt_pkg::CSR_EASE_EXPONENT, $urandom_range(0, 16'hFFFF));
            endcase
            csr_put(evt_pkg::CSR_EASE_OUT_MODE, $urandom_range(0, 1));
            csr_put(evt_pkg::CSR_START_LEVEL, pick_level());
            csr_put(evt_pkg::CSR_TARGET_LEVEL, pick_level());
         end
         dl = cfg_now.delay_time;
         du = cfg_now.ramp_duration;
         span = longint'(dl) + longint'(du);
         step = (span / 12 + 1 > 20'hFFFFF) ? 20'hFFFFF : int'(span / 12 + 1);
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(0, 99) == 0) settle();
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
               send_beat(CMD_RESTART, 20'($urandom), pin);
            end else if (sel < 15) begin
               send_beat(CMD_ADVANCE, 20'($urandom), pin);
            end else if (sel < 18) begin
               send_beat(CMD_ADVANCE, 20'hFFFFF, pin);
            end else begin
               d = 20'($urandom_range(0, step));
               send_beat(CMD_ADVANCE, d, pin);
            end
         end
      end

      settle();
      if (errors == 0) begin
         $display("eased_value_tween_tb OK");
      end else begin
         $display("eased_value_tween_tb NOT OK");
      end
      $finish;
   end

endmodule
